[rtl/vertex_attribute_to_float32_defines.svh]
// Assertion macros used by the vertex attribute converter RTL
`ifndef VERTEX_ATTRIBUTE_TO_FLOAT32_DEFINES_SVH
`define VERTEX_ATTRIBUTE_TO_FLOAT32_DEFINES_SVH

// same-cycle implication, checked outside reset
`define VATF_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("vatf check failed");

// next-cycle implication, checked outside reset
`define VATF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("vatf check failed");

`endif

[rtl/vatf_pkg.sv]
// Package: types and constants of the vertex attribute converter
`default_nettype none
package vatf_pkg;
   localparam int RawWidth   = 32;
   localparam int FloatWidth = 32;
   localparam int CsrIdxWidth  = 8;
   localparam int CsrDataWidth = 32;

   typedef logic [2:0] src_type_type;

   localparam src_type_type SRC_SBYTE  = 3'd0;
   localparam src_type_type SRC_UBYTE  = 3'd1;
   localparam src_type_type SRC_SSHORT = 3'd2;
   localparam src_type_type SRC_USHORT = 3'd3;
   localparam src_type_type SRC_HALF   = 3'd4;
   localparam src_type_type SRC_FLOAT  = 3'd5;

   localparam logic [CsrIdxWidth-1:0] CSR_SRC_KIND  = 8'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_NORMALIZE = 8'd1;

   typedef struct packed {
      src_type_type src_kind;
      logic         normalize_enable;
   } cfg_type;

   // scale exponents (biased) and mantissas with hidden bit
   localparam logic [7:0]  EXP_ONE   = 8'd127;
   localparam logic [23:0] MANT_ONE  = 24'h800000;
   localparam logic [7:0]  EXP_127   = 8'd120;
   localparam logic [23:0] MANT_127  = 24'h810204;
   localparam logic [7:0]  EXP_255   = 8'd119;
   localparam logic [23:0] MANT_255  = 24'h808081;
   localparam logic [7:0]  EXP_32767 = 8'd112;
   localparam logic [23:0] MANT_32767 = 24'h800100;
   localparam logic [7:0]  EXP_65535 = 8'd111;
   localparam logic [23:0] MANT_65535 = 24'h800080;

   localparam logic [FloatWidth-1:0] FLOAT_MINUS_ONE = 32'hBF800000;
endpackage
`default_nettype wire

[rtl/vatf_convert.sv]
// Conversion datapath: raw component word to binary32 bits
`default_nettype none
module vatf_convert (
   input  wire vatf_pkg::cfg_type               cfg,
   input  wire logic [vatf_pkg::RawWidth-1:0]   raw,
   output logic      [vatf_pkg::FloatWidth-1:0] float_bits
);
   import vatf_pkg::*;

   logic        neg;
   logic        is_min;
   logic [15:0] sval;
   logic [15:0] mag;
   logic [7:0]  sc_exp;
   logic [23:0] sc_mant;
   logic [39:0] prod;
   logic [3:0]  msb;
   logic [5:0]  lead;
   logic [5:0]  shamt;
   logic [39:0] norm;
   logic [22:0] mant;
   logic        round_up;
   logic [23:0] mant_r;
   logic [8:0]  exp_sum;
   logic [31:0] int_bits;
   logic [4:0]  h_exp;
   logic [9:0]  h_man;
   logic [3:0]  h_msb;
   logic [9:0]  h_sub;
   logic [7:0]  h_sub_exp;
   logic [31:0] half_bits;

   always_comb begin
      neg     = 1'b0;
      sval    = 16'd0;
      is_min  = 1'b0;
      sc_exp  = EXP_ONE;
      sc_mant = MANT_ONE;
      case (cfg.src_kind)
         SRC_SBYTE: begin
            neg    = raw[7];
            sval   = {{8{raw[7]}}, raw[7:0]};
            is_min = (raw[7:0] == 8'h80);
            if (cfg.normalize_enable) begin
               sc_exp  = EXP_127;
               sc_mant = MANT_127;
            end
         end
         SRC_UBYTE: begin
            sval = {8'd0, raw[7:0]};
            if (cfg.normalize_enable) begin
               sc_exp  = EXP_255;
               sc_mant = MANT_255;
            end
         end
         SRC_SSHORT: begin
            neg    = raw[15];
            sval   = raw[15:0];
            is_min = (raw[15:0] == 16'h8000);
            if (cfg.normalize_enable) begin
               sc_exp  = EXP_32767;
               sc_mant = MANT_32767;
            end
         end
         SRC_USHORT: begin
            sval = raw[15:0];
            if (cfg.normalize_enable) begin
               sc_exp  = EXP_65535;
               sc_mant = MANT_65535;
            end
         end
         default: begin
            sval = 16'd0;
         end
      endcase
   end

   assign mag  = neg ? (~sval + 16'd1) : sval;
   assign prod = 40'(mag) * 40'(sc_mant);

   always_comb begin
      msb = 4'd0;
      for (int i = 0; i < 16; i++) begin
         if (mag[i]) begin
            msb = 4'(i);
         end
      end
   end

   assign lead     = prod[6'(msb) + 6'd24] ? (6'(msb) + 6'd24) : (6'(msb) + 6'd23);
   assign shamt    = 6'd39 - lead;
   assign norm     = prod << shamt;
   assign mant     = norm[38:16];
   assign round_up = norm[15] & ((|norm[14:0]) | norm[16]);
   assign mant_r   = {1'b0, mant} + 24'(round_up);
   assign exp_sum  = 9'(lead) + 9'(sc_exp) - 9'd23 + 9'(mant_r[23]);

   always_comb begin
      if (mag == 16'd0) begin
         int_bits = 32'd0;
      end else if (cfg.normalize_enable && is_min) begin
         int_bits = FLOAT_MINUS_ONE;
      end else begin
         int_bits = {neg, exp_sum[7:0], mant_r[22:0]};
      end
   end

   assign h_exp = raw[14:10];
   assign h_man = raw[9:0];

   always_comb begin
      h_msb = 4'd0;
      for (int i = 0; i < 10; i++) begin
         if (h_man[i]) begin
            h_msb = 4'(i);
         end
      end
   end

   assign h_sub     = h_man << (4'd10 - h_msb);
   assign h_sub_exp = 8'd103 + 8'(h_msb);

   always_comb begin
      if (h_exp == 5'd0) begin
         if (h_man == 10'd0) begin
            half_bits = {raw[15], 31'd0};
         end else begin
            half_bits = {raw[15], h_sub_exp, h_sub, 13'd0};
         end
      end else if (h_exp == 5'h1F) begin
         half_bits = {raw[15], 8'hFF, h_man, 13'd0};
      end else begin
         half_bits = {raw[15], 8'(h_exp) + 8'd112, h_man, 13'd0};
      end
   end

   always_comb begin
      case (cfg.src_kind)
         SRC_SBYTE, SRC_UBYTE, SRC_SSHORT, SRC_USHORT: float_bits = int_bits;
         SRC_HALF:  float_bits = half_bits;
         SRC_FLOAT: float_bits = raw;
         default:   float_bits = 32'd0;
      endcase
   end
endmodule
`default_nettype wire

[rtl/vertex_attribute_to_float32.sv]
// Top level: vertex attribute component to binary32 converter
// channel | dir | handshake          | word
// req     | in  | req_valid/stall    | raw_component, last_in
// rsp     | out | rsp_valid/stall    | float_bits, last_out
// csr     | in  | csr_valid/ready    | index, data
// One word per cycle sustained while rsp_stall stays low; a word passes the input register, then the result register.
// The conversion (for integer sources one 16x24 multiply with normalize and round) sits between the two.
// Synchronous active-high reset clears valids and config (sbyte, no normalize).
// A stalled result holds; the input register still fills behind it.
`default_nettype none
`include "vertex_attribute_to_float32_defines.svh"
module vertex_attribute_to_float32 (
   input  wire  logic                               clock,
   input  wire  logic                               reset,
   input  wire  logic                               req_valid,
   output logic                                     req_stall,
   input  wire  logic [vatf_pkg::RawWidth-1:0]      req_raw_component,
   input  wire  logic                               req_last_in,
   output logic                                     rsp_valid,
   input  wire  logic                               rsp_stall,
   output logic       [vatf_pkg::FloatWidth-1:0]    rsp_float_bits,
   output logic                                     rsp_last_out,
   input  wire  logic                               csr_valid,
   output logic                                     csr_ready,
   input  wire  logic [vatf_pkg::CsrIdxWidth-1:0]   csr_index,
   input  wire  logic [vatf_pkg::CsrDataWidth-1:0]  csr_data
);
   import vatf_pkg::*;

   cfg_type                cfg_ff;
   cfg_type                cfg_in;
   logic                   s1_valid_ff;
   logic                   s1_valid_in;
   logic [RawWidth-1:0]    s1_raw_ff;
   logic                   s1_last_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [FloatWidth-1:0]  rsp_bits_ff;
   logic                   rsp_last_ff;
   logic [FloatWidth-1:0]  conv_bits;
   logic                   rsp_load;
   logic                   req_take;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_SRC_KIND) begin
            cfg_in.src_kind = csr_data[2:0];
         end else if (csr_index == CSR_NORMALIZE) begin
            cfg_in.normalize_enable = csr_data[0];
         end
      end
   end

   assign rsp_load     = !rsp_valid_ff || !rsp_stall;
   assign req_stall    = s1_valid_ff && !rsp_load;
   assign req_take     = req_valid && !req_stall;
   assign s1_valid_in  = req_take || (s1_valid_ff && !rsp_load);
   assign rsp_valid_in = rsp_load ? s1_valid_ff : rsp_valid_ff;

   vatf_convert u_convert (
      .cfg        (cfg_ff),
      .raw        (s1_raw_ff),
      .float_bits (conv_bits)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_raw_ff  <= req_raw_component;
         s1_last_ff <= req_last_in;
      end
      if (rsp_load && s1_valid_ff) begin
         rsp_bits_ff <= conv_bits;
         rsp_last_ff <= s1_last_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_float_bits = rsp_bits_ff;
   assign rsp_last_out   = rsp_last_ff;

   `VATF_ASSERT_IMPL(a_block_when_full, s1_valid_ff && rsp_valid_ff && rsp_stall, req_stall)
   `VATF_ASSERT_NEXT(a_s1_drains, s1_valid_ff && !(rsp_valid_ff && rsp_stall), rsp_valid_ff)
   `VATF_ASSERT_IMPL(a_rsp_from_s1, rsp_valid_ff && !$past(rsp_valid_ff), $past(s1_valid_ff))
   `VATF_ASSERT_NEXT(a_take_fills, req_valid && !req_stall, s1_valid_ff)
endmodule
`default_nettype wire
